>>> rtl/ffsa_pkg.sv
`default_nettype none
package ffsa_pkg;

    typedef enum logic [2:0] {
        CMD_APPEND   = 3'd0,
        CMD_FREE     = 3'd1,
        CMD_COALESCE = 3'd2,
        CMD_FIT      = 3'd3,
        CMD_READ     = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NOFIT = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_SPLIT_LO,
        S_SPLIT_HI,
        S_READ,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] amount;
        logic [3:0]  entry_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] entry_size;
        logic        entry_is_hole;
        logic [4:0]  segment_count;
        logic [19:0] free_total;
    } t_out_item;

endpackage
`default_nettype wire

>>> rtl/first_fit_segment_allocator_top.sv
// first-fit segment allocator
// keeps an ordered table of segments (size plus hole flag) in a single-port-write,
// single-port-read synchronous ram; count and total hole size live in registers
// input channel: i_in_valid / o_in_stall carry one command (append, free by size,
// coalesce, first fit, read entry); a transfer happens when valid is high and
// stall is low
// output channel: o_out_valid / i_out_stall carry exactly one result per command
// free and coalesce walk the whole table; first fit stops at the first hole that fits,
// turns it into a process entry on an exact fit, and otherwise shifts the tail up one
// entry and writes the two split halves when the table is not full
// one command is in work at a time: the ram read port walks the table one entry
// per cycle; the next command is taken the cycle after the result register loads
// the result sits in an output register, so a stalled receiver only holds the
// next command's completion, never the current result
// reset clears the count, the hole total and the control state; the ram is not
// cleared, entries at or beyond the count are never read
`default_nettype none
module first_fit_segment_allocator_top
    import ffsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16,
    parameter int SIZE_BITS    = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    localparam int ADDR_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int FREE_W = SIZE_BITS + $clog2(MAX_SEGMENTS) + 1;
    localparam int WORD_W = SIZE_BITS + 1;

    // control state
    t_state r_state, n_state;
    logic [CNT_W-1:0]  r_count;
    logic [FREE_W-1:0] r_free;
    logic [CNT_W-1:0]  r_rd;      // next address to read
    logic [CNT_W-1:0]  r_wr;      // coalesce write pointer
    logic              r_vld_d;   // ram data valid this cycle
    logic              r_out_vld;

    // payload
    logic [2:0]           r_cmd;
    logic [SIZE_BITS-1:0] r_amt;
    logic [ADDR_W-1:0]    r_addr_d;  // address of the data now on the ram output
    logic [ADDR_W-1:0]    r_pos;     // position of the split hole
    logic [SIZE_BITS-1:0] r_rest;
    logic [SIZE_BITS-1:0] r_last_size;
    logic                 r_last_hole;
    t_status              r_status;
    logic [SIZE_BITS-1:0] r_esize;
    logic                 r_ehole;
    t_out_item            r_out;

    // ram port
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;

    ffsa_ram #(
        .DEPTH (MAX_SEGMENTS),
        .WIDTH (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    logic                 in_xfer, out_xfer;
    logic                 full;
    logic                 rd_hole;
    logic [SIZE_BITS-1:0] rd_size;
    logic [SIZE_BITS:0]   merge_sum;
    logic                 merge;
    logic                 fit_hit;
    logic                 read_ok;
    logic                 issue;
    logic                 scan_end;
    logic                 shift_end;
    logic                 slot_free;

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign out_xfer  = r_out_vld && !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign full      = (r_count == CNT_W'(MAX_SEGMENTS));
    assign rd_hole   = mem_rdata[SIZE_BITS];
    assign rd_size   = mem_rdata[SIZE_BITS-1:0];
    assign merge_sum = {1'b0, r_last_size} + {1'b0, rd_size};
    // a hole only joins the previous run if the merged size still fits
    assign merge     = (r_wr != '0) && rd_hole && r_last_hole && !merge_sum[SIZE_BITS];
    // only the search looks for a hit, the tail shift reuses the read path
    assign fit_hit   = (r_state == S_SCAN) && r_vld_d && (r_cmd == CMD_FIT) && rd_hole
                     && (rd_size >= r_amt);
    assign read_ok   = (32'(i_in_data.entry_index) < 32'(r_count));
    assign issue     = (r_state == S_SCAN) ? ((r_rd < r_count) && !fit_hit)
                     : (r_state == S_SHIFT) ? (r_rd > CNT_W'(r_pos)) : 1'b0;
    assign scan_end  = (r_state == S_SCAN) && !issue && !r_vld_d;
    assign shift_end = (r_state == S_SHIFT) && !issue && !r_vld_d;
    assign slot_free = !r_out_vld || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_in_data.cmd)
                        CMD_FREE, CMD_COALESCE, CMD_FIT: n_state = S_SCAN;
                        CMD_READ: n_state = read_ok ? S_READ : S_FIN;
                        default:  n_state = S_FIN;
                    endcase
                end
            end
            S_SCAN: begin
                if (fit_hit) begin
                    if (rd_size == r_amt || full) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (scan_end) begin
                    n_state = S_FIN;
                end
            end
            S_SHIFT:    if (shift_end) n_state = S_SPLIT_LO;
            S_SPLIT_LO: n_state = S_SPLIT_HI;
            S_SPLIT_HI: n_state = S_FIN;
            S_READ:     n_state = S_FIN;
            S_FIN:      if (slot_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // ram control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = issue;
        mem_raddr = r_rd[ADDR_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (in_xfer && i_in_data.cmd == CMD_APPEND && !full) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_count[ADDR_W-1:0];
                    mem_wdata = {1'b0, SIZE_BITS'(i_in_data.amount)};
                end
                mem_re    = in_xfer && (i_in_data.cmd == CMD_READ) && read_ok;
                mem_raddr = ADDR_W'(i_in_data.entry_index);
            end
            S_SCAN: begin
                if (r_vld_d) begin
                    case (r_cmd)
                        CMD_FREE: begin
                            mem_we    = (rd_size == r_amt);
                            mem_waddr = r_addr_d;
                            mem_wdata = {1'b1, rd_size};
                        end
                        CMD_COALESCE: begin
                            mem_we = 1'b1;
                            if (merge) begin
                                mem_waddr = ADDR_W'(r_wr - 1'b1);
                                mem_wdata = {1'b1, merge_sum[SIZE_BITS-1:0]};
                            end else begin
                                mem_waddr = r_wr[ADDR_W-1:0];
                                mem_wdata = mem_rdata;
                            end
                        end
                        default: begin
                            // exact fit just turns the hole into a process
                            mem_we    = fit_hit && (rd_size == r_amt);
                            mem_waddr = r_addr_d;
                            mem_wdata = {1'b0, rd_size};
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                mem_we    = r_vld_d;
                mem_waddr = r_addr_d + 1'b1;
                mem_wdata = mem_rdata;
            end
            S_SPLIT_LO: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = {1'b0, r_amt};
            end
            S_SPLIT_HI: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos + 1'b1;
                mem_wdata = {1'b1, r_rest};
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_free    <= '0;
            r_rd      <= '0;
            r_wr      <= '0;
            r_vld_d   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld_d <= issue;
            if (out_xfer) begin
                r_out_vld <= 1'b0;
            end
            if (r_state == S_FIN && slot_free) begin
                r_out_vld <= 1'b1;
            end
            if (issue) begin
                r_rd <= (r_state == S_SHIFT) ? r_rd - 1'b1 : r_rd + 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    r_rd <= '0;
                    r_wr <= '0;
                    if (in_xfer && i_in_data.cmd == CMD_APPEND && !full) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (r_vld_d) begin
                        case (r_cmd)
                            CMD_FREE: begin
                                if (rd_size == r_amt && !rd_hole) begin
                                    r_free <= r_free + FREE_W'(rd_size);
                                end
                            end
                            CMD_COALESCE: begin
                                if (!merge) r_wr <= r_wr + 1'b1;
                            end
                            default: begin
                                if (fit_hit) begin
                                    if (rd_size == r_amt) begin
                                        r_free <= r_free - FREE_W'(r_amt);
                                    end
                                    r_rd <= r_count - 1'b1;
                                end
                            end
                        endcase
                    end
                    if (scan_end && r_cmd == CMD_COALESCE) begin
                        r_count <= r_wr;
                    end
                end
                S_SPLIT_HI: begin
                    r_count <= r_count + 1'b1;
                    r_free  <= r_free - FREE_W'(r_amt);
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr_d <= mem_raddr;
        if (in_xfer) begin
            r_cmd    <= i_in_data.cmd;
            r_amt    <= SIZE_BITS'(i_in_data.amount);
            r_esize  <= '0;
            r_ehole  <= 1'b0;
            r_status <= ST_OK;
            if (i_in_data.cmd == CMD_APPEND && full) begin
                r_status <= ST_FULL;
            end
            if (i_in_data.cmd == CMD_READ && !read_ok) begin
                r_status <= ST_RANGE;
            end
        end
        if (r_state == S_SCAN && r_vld_d && r_cmd == CMD_COALESCE) begin
            r_last_hole <= rd_hole;
            r_last_size <= merge ? merge_sum[SIZE_BITS-1:0] : rd_size;
        end
        if (fit_hit) begin
            r_pos  <= r_addr_d;
            r_rest <= rd_size - r_amt;
            if (rd_size != r_amt && full) begin
                r_status <= ST_FULL;
            end
        end
        if (scan_end && r_cmd == CMD_FIT) begin
            r_status <= ST_NOFIT;
        end
        if (r_state == S_READ) begin
            r_esize <= rd_size;
            r_ehole <= rd_hole;
        end
        if (r_state == S_FIN && slot_free) begin
            r_out.status        <= r_status;
            r_out.entry_size    <= 16'(r_esize);
            r_out.entry_is_hole <= r_ehole;
            r_out.segment_count <= 5'(r_count);
            r_out.free_total    <= 20'(r_free);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count beyond table depth");

    a_split_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT_HI) |=> (r_count == $past(r_count) + 1'b1))
        else $error("split did not add one segment");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("new command taken before result produced");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |=> r_out_vld)
        else $error("stalled result dropped");

endmodule
`default_nettype wire

>>> rtl/ffsa_ram.sv
`default_nettype none
module ffsa_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 17
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> sim/ffsa_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module ffsa_checker
    import ffsa_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_item  i_in_data,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_item i_out_data,
    output int             o_fail_count,
    output int             o_pending
);

    localparam int NSEG = 16;

    logic [15:0] seg_size [NSEG];
    logic        seg_hole [NSEG];
    int          seg_count;
    t_out_item   result_queue [$];

    function automatic logic [19:0] hole_total();
        logic [19:0] s;
        s = '0;
        for (int i = 0; i < seg_count; i++)
            if (seg_hole[i]) s += 20'(seg_size[i]);
        return s;
    endfunction

    // applies one command to the shadow table and returns the predicted result
    function automatic t_out_item apply_command(t_in_item it);
        t_out_item r;
        int wr;
        int pos;
        logic [16:0] merged;
        r = '0;
        r.status = ST_OK;
        case (it.cmd)
            CMD_APPEND: begin
                if (seg_count >= NSEG) begin
                    r.status = ST_FULL;
                end else begin
                    seg_size[seg_count] = it.amount;
                    seg_hole[seg_count] = 1'b0;
                    seg_count++;
                end
            end
            CMD_FREE: begin
                for (int i = 0; i < seg_count; i++)
                    if (seg_size[i] == it.amount) seg_hole[i] = 1'b1;
            end
            CMD_COALESCE: begin
                wr = 0;
                for (int rd = 0; rd < seg_count; rd++) begin
                    merged = (wr > 0) ? {1'b0, seg_size[wr-1]} + {1'b0, seg_size[rd]} : '0;
                    if (wr > 0 && seg_hole[rd] && seg_hole[wr-1] && !merged[16]) begin
                        seg_size[wr-1] = merged[15:0];
                    end else begin
                        seg_size[wr] = seg_size[rd];
                        seg_hole[wr] = seg_hole[rd];
                        wr++;
                    end
                end
                seg_count = wr;
            end
            CMD_FIT: begin
                pos = -1;
                for (int i = 0; i < seg_count; i++)
                    if (pos < 0 && seg_hole[i] && seg_size[i] >= it.amount) pos = i;
                if (pos < 0) begin
                    r.status = ST_NOFIT;
                end else if (seg_size[pos] == it.amount) begin
                    seg_hole[pos] = 1'b0;
                end else if (seg_count >= NSEG) begin
                    r.status = ST_FULL;
                end else begin
                    for (int j = seg_count; j > pos + 1; j--) begin
                        seg_size[j] = seg_size[j-1];
                        seg_hole[j] = seg_hole[j-1];
                    end
                    seg_size[pos+1] = seg_size[pos] - it.amount;
                    seg_hole[pos+1] = 1'b1;
                    seg_size[pos] = it.amount;
                    seg_hole[pos] = 1'b0;
                    seg_count++;
                end
            end
            CMD_READ: begin
                if (int'(it.entry_index) < seg_count) begin
                    r.entry_size = seg_size[it.entry_index];
                    r.entry_is_hole = seg_hole[it.entry_index];
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default: ;
        endcase
        r.segment_count = 5'(seg_count);
        r.free_total = hole_total();
        return r;
    endfunction

    assign o_pending = result_queue.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            seg_count = 0;
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                result_queue.push_back(apply_command(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (result_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result %h", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = result_queue.pop_front();
                    if (want !== i_out_data) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: st %0d/%0d size %0d/%0d hole %0d/%0d",
                                      " cnt %0d/%0d free %0d/%0d"},
                                want.status, i_out_data.status,
                                want.entry_size, i_out_data.entry_size,
                                want.entry_is_hole, i_out_data.entry_is_hole,
                                want.segment_count, i_out_data.segment_count,
                                want.free_total, i_out_data.free_total);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> sim/tb_first_fit_segment_allocator_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_first_fit_segment_allocator_top;
    import ffsa_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;
    int        fail_count;
    int        pending;
    int        cycle_count = 0;

    first_fit_segment_allocator_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    ffsa_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // mostly no gap at all, otherwise a short one, now and then a long one
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // watchdog: sized for the slowest run of ~1500 items, each with the worst busy time, gap and stall
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("first_fit_segment_allocator_top verification failed");
            $finish;
        end
    end

    // receiver side stall pattern, random run lengths
    initial begin
        int n;
        out_stall = 1'b0;
        forever begin
            n = gap_length();
            repeat (n) begin
                @(posedge clk);
                out_stall <= 1'b1;
            end
            n = $urandom_range(1, 12);
            repeat (n) begin
                @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // one transfer on the input channel, then an optional idle gap
    task automatic send_command(t_cmd c, logic [15:0] amt, logic [3:0] idx);
        int g;
        in_valid <= 1'b1;
        in_data  <= '{cmd: c, amount: amt, entry_index: idx};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        g = gap_length();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // sizes biased toward small values so frees and fits match often
    function automatic logic [15:0] pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 16'($urandom_range(1, 12));
        if (r < 8) return 16'($urandom_range(0, 65535));
        return (r == 8) ? 16'hFFFF : 16'h8000 | 16'($urandom_range(0, 32767));
    endfunction

    initial begin
        logic [2:0] raw;
        int r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, full table, overflow during coalesce, fits
        send_command(CMD_READ, 16'd0, 4'd0);
        send_command(CMD_FIT, 16'd1, 4'd0);
        send_command(CMD_COALESCE, 16'd0, 4'd0);
        send_command(CMD_FREE, 16'd5, 4'd0);
        for (int i = 0; i < 16; i++)
            send_command(CMD_APPEND, (i < 3) ? 16'hFFFF : 16'(i), 4'(i));
        send_command(CMD_APPEND, 16'd0, 4'd0);
        send_command(CMD_FREE, 16'hFFFF, 4'd0);
        send_command(CMD_COALESCE, 16'd0, 4'd0);
        send_command(CMD_FIT, 16'd100, 4'd0);
        send_command(CMD_FIT, 16'hFFFF, 4'd0);
        in_valid <= 1'b1;
        in_data  <= '{cmd: 3'd7, amount: 16'h5A5A, entry_index: 4'hF};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        send_command(CMD_READ, 16'hFFFF, 4'd15);

        // random: mixture weighted toward append/free/fit so the table churns
        for (int n = 0; n < 1400; n++) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                raw = 3'($urandom_range(5, 7));
                in_valid <= 1'b1;
                in_data  <= '{cmd: raw, amount: 16'($urandom), entry_index: 4'($urandom)};
                @(posedge clk);
                while (in_stall) @(posedge clk);
            end else if (r < 25) begin
                send_command(CMD_APPEND, pick_size(), 4'($urandom));
            end else if (r < 42) begin
                send_command(CMD_FREE, pick_size(), 4'($urandom));
            end else if (r < 52) begin
                send_command(CMD_COALESCE, 16'($urandom), 4'($urandom));
            end else if (r < 72) begin
                send_command(CMD_FIT, pick_size(), 4'($urandom));
            end else begin
                send_command(CMD_READ, 16'($urandom), 4'($urandom));
            end
            // occasionally free every segment of size 0 to 12 and then coalesce the table
            if ($urandom_range(0, 199) == 0) begin
                for (int s = 0; s < 13; s++) send_command(CMD_FREE, 16'(s), 4'd0);
                send_command(CMD_COALESCE, 16'd0, 4'd0);
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0) begin
            $display("first_fit_segment_allocator_top verification clean");
        end else begin
            $display("first_fit_segment_allocator_top verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> files.f
rtl/ffsa_pkg.sv
rtl/ffsa_ram.sv
rtl/first_fit_segment_allocator_top.sv
sim/ffsa_checker.sv
sim/tb_first_fit_segment_allocator_top.sv
